### hdl/linked_node_table_engine_unit_defines.svh
// ---------------------------------------------------------------------------
// Linked node table engine assertion macros
// Shared assertion forms for the linked node table engine. Each macro samples
// on the rising edge of clk and is disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef LINKED_NODE_TABLE_ENGINE_UNIT_DEFINES_SVH
`define LINKED_NODE_TABLE_ENGINE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LNTE_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("linked node table engine: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LNTE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("linked node table engine: next-cycle check failed");

`endif

### hdl/lnte_pkg.sv
// ---------------------------------------------------------------------------
// Linked node table engine package
// Command codes, the queued command record, queue status and node helpers
// shared by the front end, the command queue and the execution back end.
// ---------------------------------------------------------------------------
`default_nettype none

package lnte_pkg;

	// Default node count.
	localparam int unsigned NODES_DEFAULT = 64;

	// Depth of the queue between the front end and the back end.
	localparam int unsigned QUEUE_DEPTH = 2;

	// Width of node numbers on the ports and in the link tables.
	localparam int unsigned NODE_W = 7;

	// Mode codes as they arrive on the command port.
	localparam logic [2:0] MODE_SPLIT_AFTER  = 3'd0;
	localparam logic [2:0] MODE_SPLIT_BEFORE = 3'd1;
	localparam logic [2:0] MODE_LINK         = 3'd2;
	localparam logic [2:0] MODE_VISIT_FWD    = 3'd3;
	localparam logic [2:0] MODE_VISIT_BWD    = 3'd4;

	// Classified operation carried through the queue.
	typedef logic [2:0] op_t;
	localparam op_t OP_NONE         = 3'd0;
	localparam op_t OP_SPLIT_AFTER  = 3'd1;
	localparam op_t OP_SPLIT_BEFORE = 3'd2;
	localparam op_t OP_LINK         = 3'd3;
	localparam op_t OP_VISIT_FWD    = 3'd4;
	localparam op_t OP_VISIT_BWD    = 3'd5;

	typedef logic [NODE_W-1:0] node_t;

	// One classified command as stored in the queue.
	typedef struct packed {
		op_t   op;
		node_t node_x;
		node_t node_y;
		logic  x_ok;
		logic  y_ok;
	} cmd_t;

	// Queue status seen by the front end and the back end.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// A node number is usable when it lies in 1..n.
	function automatic logic node_ok(input node_t v, input int unsigned n);
		return (v != '0) && (int'(v) <= int'(n));
	endfunction

endpackage

`default_nettype wire

### hdl/lnte_front.sv
// ---------------------------------------------------------------------------
// Linked node table engine front end
// Accepts command transactions, classifies the mode and checks the node
// numbers, and pushes the classified command into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module lnte_front #(
	parameter int unsigned NODES = lnte_pkg::NODES_DEFAULT
) (
	input  wire logic                  start,
	input  wire logic [2:0]            mode,
	input  wire lnte_pkg::node_t       node_x,
	input  wire lnte_pkg::node_t       node_y,
	input  wire lnte_pkg::queue_status_t q_status,
	output logic                       busy,
	output logic                       push,
	output lnte_pkg::cmd_t             cmd
);

	// The front end stalls only when the queue has no free entry.
	assign busy = q_status.full;
	assign push = start && !q_status.full;

	// Map the mode onto an operation; unused modes become a no-op.
	always_comb begin
		cmd.node_x = node_x;
		cmd.node_y = node_y;
		cmd.x_ok   = lnte_pkg::node_ok(node_x, NODES);
		cmd.y_ok   = lnte_pkg::node_ok(node_y, NODES);
		case (mode)
			lnte_pkg::MODE_SPLIT_AFTER:  cmd.op = lnte_pkg::OP_SPLIT_AFTER;
			lnte_pkg::MODE_SPLIT_BEFORE: cmd.op = lnte_pkg::OP_SPLIT_BEFORE;
			lnte_pkg::MODE_LINK:         cmd.op = lnte_pkg::OP_LINK;
			lnte_pkg::MODE_VISIT_FWD:    cmd.op = lnte_pkg::OP_VISIT_FWD;
			lnte_pkg::MODE_VISIT_BWD:    cmd.op = lnte_pkg::OP_VISIT_BWD;
			default:                     cmd.op = lnte_pkg::OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

### hdl/lnte_cmd_queue.sv
// ---------------------------------------------------------------------------
// Linked node table engine command queue
// A short register queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module lnte_cmd_queue (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	input  wire lnte_pkg::cmd_t          push_cmd,
	input  wire logic                    pop,
	output lnte_pkg::cmd_t               head,
	output lnte_pkg::queue_status_t      status,
	output logic [$clog2(lnte_pkg::QUEUE_DEPTH+1)-1:0] count
);

	localparam int unsigned DEPTH = lnte_pkg::QUEUE_DEPTH;
	localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	lnte_pkg::cmd_t entry_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign head         = entry_q[rd_ptr_q];
	assign count        = count_q;
	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);

	// Pointer and fill count update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Entry storage holds payload only.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

### hdl/lnte_back.sv
// ---------------------------------------------------------------------------
// Linked node table engine back end
// Holds the successor and predecessor link tables and carries out queued
// commands: read-modify-write for split and link, one node a cycle for visits.
// ---------------------------------------------------------------------------
`default_nettype none

module lnte_back #(
	parameter int unsigned NODES = lnte_pkg::NODES_DEFAULT
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire lnte_pkg::cmd_t          head,
	input  wire lnte_pkg::queue_status_t q_status,
	output logic                         pop,
	output logic                         strobe,
	output logic                         success,
	output lnte_pkg::node_t              node_id,
	output logic                         last
);

	localparam int unsigned AW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int unsigned CW = $clog2(NODES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;

	logic [1:0]      state_q;
	logic [1:0]      state_d;
	lnte_pkg::cmd_t  cmd_q;
	lnte_pkg::node_t cur_q;
	lnte_pkg::node_t cur_d;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   cnt_d;

	// Link tables with per-entry valid bits; an unwritten entry reads as no link.
	lnte_pkg::node_t succ_mem [NODES];
	lnte_pkg::node_t pred_mem [NODES];
	lnte_pkg::node_t succ_rd_q;
	lnte_pkg::node_t pred_rd_q;
	logic [AW-1:0]   succ_ra_q;
	logic [AW-1:0]   pred_ra_q;
	logic [NODES-1:0] succ_vld_q;
	logic [NODES-1:0] pred_vld_q;

	logic [AW-1:0]   succ_ra;
	logic [AW-1:0]   pred_ra;
	logic            succ_we;
	logic [AW-1:0]   succ_wa;
	lnte_pkg::node_t succ_wd;
	logic            pred_we;
	logic [AW-1:0]   pred_wa;
	lnte_pkg::node_t pred_wd;

	lnte_pkg::node_t succ_link;
	lnte_pkg::node_t pred_link;
	lnte_pkg::node_t walk_link;
	logic            walk_more;

	logic            emit;
	logic            emit_ok;
	lnte_pkg::node_t emit_id;
	logic            emit_last;

	logic            strobe_q;
	logic            success_q;
	lnte_pkg::node_t node_id_q;
	logic            last_q;

	function automatic logic [AW-1:0] to_idx(input lnte_pkg::node_t v);
		lnte_pkg::node_t m;
		m = v - lnte_pkg::node_t'(1);
		return m[AW-1:0];
	endfunction

	// Effective link values of the entries read in the previous cycle.
	assign succ_link = succ_vld_q[succ_ra_q] ? succ_rd_q : '0;
	assign pred_link = pred_vld_q[pred_ra_q] ? pred_rd_q : '0;
	assign walk_link = (cmd_q.op == lnte_pkg::OP_VISIT_FWD) ? succ_link : pred_link;

	// A walk goes on while the link is a real node, not the start, and under the bound.
	assign walk_more = lnte_pkg::node_ok(walk_link, NODES) && (walk_link != cmd_q.node_x)
		&& (cnt_q < CW'(NODES - 1));

	// Command sequencer.
	always_comb begin
		state_d   = state_q;
		cur_d     = cur_q;
		cnt_d     = cnt_q;
		pop       = 1'b0;
		succ_ra   = to_idx(cmd_q.node_x);
		pred_ra   = to_idx(cmd_q.node_x);
		succ_we   = 1'b0;
		succ_wa   = to_idx(cmd_q.node_x);
		succ_wd   = '0;
		pred_we   = 1'b0;
		pred_wa   = to_idx(cmd_q.node_x);
		pred_wd   = '0;
		emit      = 1'b0;
		emit_ok   = 1'b0;
		emit_id   = '0;
		emit_last = 1'b1;
		case (state_q)
			ST_IDLE: begin
				succ_ra = to_idx(head.node_x);
				pred_ra = (head.op == lnte_pkg::OP_LINK) ? to_idx(head.node_y)
					: to_idx(head.node_x);
				if (!q_status.empty) begin
					pop = 1'b1;
					case (head.op)
						lnte_pkg::OP_SPLIT_AFTER,
						lnte_pkg::OP_SPLIT_BEFORE,
						lnte_pkg::OP_LINK: begin
							state_d = ST_EXEC;
						end
						lnte_pkg::OP_VISIT_FWD,
						lnte_pkg::OP_VISIT_BWD: begin
							if (head.x_ok) begin
								state_d = ST_WALK;
								cur_d   = head.node_x;
								cnt_d   = '0;
							end else begin
								emit    = 1'b1;
								emit_ok = 1'b1;
								emit_id = head.node_x;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			ST_EXEC: begin
				emit    = 1'b1;
				state_d = ST_IDLE;
				case (cmd_q.op)
					lnte_pkg::OP_SPLIT_AFTER: begin
						if (cmd_q.x_ok && (succ_link != '0)) begin
							emit_ok = 1'b1;
							succ_we = 1'b1;
							pred_we = lnte_pkg::node_ok(succ_link, NODES);
							pred_wa = to_idx(succ_link);
						end
					end
					lnte_pkg::OP_SPLIT_BEFORE: begin
						if (cmd_q.x_ok && (pred_link != '0)) begin
							emit_ok = 1'b1;
							pred_we = 1'b1;
							succ_we = lnte_pkg::node_ok(pred_link, NODES);
							succ_wa = to_idx(pred_link);
						end
					end
					lnte_pkg::OP_LINK: begin
						if (cmd_q.x_ok && cmd_q.y_ok && (succ_link == '0)
							&& (pred_link == '0)) begin
							emit_ok = 1'b1;
							succ_we = 1'b1;
							succ_wd = cmd_q.node_y;
							pred_we = 1'b1;
							pred_wa = to_idx(cmd_q.node_y);
							pred_wd = cmd_q.node_x;
						end
					end
					default: begin
						emit_ok = 1'b0;
					end
				endcase
			end
			ST_WALK: begin
				succ_ra   = to_idx(walk_link);
				pred_ra   = to_idx(walk_link);
				emit      = 1'b1;
				emit_ok   = 1'b1;
				emit_id   = cur_q;
				emit_last = !walk_more;
				if (walk_more) begin
					cur_d = walk_link;
					cnt_d = cnt_q + CW'(1);
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state and the valid bits of the link tables.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			strobe_q   <= 1'b0;
			succ_vld_q <= '0;
			pred_vld_q <= '0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			if (succ_we) begin
				succ_vld_q[succ_wa] <= 1'b1;
			end
			if (pred_we) begin
				pred_vld_q[pred_wa] <= 1'b1;
			end
		end
	end

	// Command and walk registers plus the result payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		cur_q     <= cur_d;
		cnt_q     <= cnt_d;
		success_q <= emit_ok;
		node_id_q <= emit_id;
		last_q    <= emit_last;
	end

	// Successor table: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (succ_we) begin
			succ_mem[succ_wa] <= succ_wd;
		end
		succ_rd_q <= succ_mem[succ_ra];
		succ_ra_q <= succ_ra;
	end

	// Predecessor table: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (pred_we) begin
			pred_mem[pred_wa] <= pred_wd;
		end
		pred_rd_q <= pred_mem[pred_ra];
		pred_ra_q <= pred_ra;
	end

	assign strobe  = strobe_q;
	assign success = success_q;
	assign node_id = node_id_q;
	assign last    = last_q;

endmodule

`default_nettype wire

### hdl/linked_node_table_engine_unit.sv
// ---------------------------------------------------------------------------
// Linked node table engine
// An index-based doubly linked list of NODES numbered nodes with split, link
// and visit commands.
// ---------------------------------------------------------------------------
// Usage:
// A command transaction is taken at a rising edge with start high and busy
// low; mode, node_x and node_y are sampled there. Commands wait in a two-entry
// queue, so busy rises only when the queue is full.
// Results leave on success, node_id and last, each valid for exactly one
// cycle while strobe is high; the receiver cannot stall them.
// With the back end idle, split and link leave the queue while both link
// tables are read, then write the tables while the result is registered.
// Unused modes and visits from an invalid node strobe straight from the
// idle state as they leave the queue, without a table write.
// A visit strobes its start node and then one node per cycle, back to back,
// the last with last high; each step waits on the registered read of the
// link table.
// Reset clears the queue, the sequencer and the valid bits of both link
// tables, so every node starts with no links; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

`include "linked_node_table_engine_unit_defines.svh"

module linked_node_table_engine_unit #(
	parameter int unsigned NODES = lnte_pkg::NODES_DEFAULT
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [2:0]      mode,
	input  wire lnte_pkg::node_t node_x,
	input  wire lnte_pkg::node_t node_y,
	output logic                 busy,
	output logic                 strobe,
	output logic                 success,
	output lnte_pkg::node_t      node_id,
	output logic                 last
);

	logic                    push;
	logic                    pop;
	lnte_pkg::cmd_t          push_cmd;
	lnte_pkg::cmd_t          head;
	lnte_pkg::queue_status_t q_status;
	logic [$clog2(lnte_pkg::QUEUE_DEPTH+1)-1:0] q_count;

	// Front end: accept and classify.
	lnte_front #(
		.NODES(NODES)
	) u_front (
		.start    (start),
		.mode     (mode),
		.node_x   (node_x),
		.node_y   (node_y),
		.q_status (q_status),
		.busy     (busy),
		.push     (push),
		.cmd      (push_cmd)
	);

	// Queue between the two halves.
	lnte_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (q_status),
		.count    (q_count)
	);

	// Back end: link tables and command execution.
	lnte_back #(
		.NODES(NODES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.strobe   (strobe),
		.success  (success),
		.node_id  (node_id),
		.last     (last)
	);

	// Checks on the decoupling queue and the result stream.
	`LNTE_ASSERT_SAME(a_pop_not_empty, pop, !q_status.empty)
	`LNTE_ASSERT_NEXT(a_push_grows, push && !pop, q_count == $past(q_count) + 1'b1)
	`LNTE_ASSERT_SAME(a_node_result_ok, strobe && (node_id != '0), success)
	`LNTE_ASSERT_NEXT(a_visit_contiguous, strobe && !last, strobe)

endmodule

`default_nettype wire
